// ===== hdl/cbea_pkg.sv =====
// Shared types, codes and rounding helper for the cubic-bezier easing animator.
package cbea_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_CHK,
        S_EVAL,
        S_CMP,
        S_VAL,
        S_OUT
    } cbea_state_t;

    typedef enum logic [1:0] {
        KIND_ANIMATE   = 2'd0,
        KIND_ONE_WAY   = 2'd1,
        KIND_ROUND_TRIP = 2'd2,
        KIND_NONE      = 2'd3
    } cbea_kind_t;

    localparam logic [2:0] CFG_DURATION = 3'd0;
    localparam logic [2:0] CFG_X1       = 3'd1;
    localparam logic [2:0] CFG_Y1       = 3'd2;
    localparam logic [2:0] CFG_X2       = 3'd3;
    localparam logic [2:0] CFG_Y2       = 3'd4;
    localparam logic [2:0] CFG_START    = 3'd5;
    localparam logic [2:0] CFG_END      = 3'd6;

    localparam logic [16:0] PROGRESS_DONE = 17'd65536;

    // Divide by 2^s, round to nearest, halves away from zero.
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                     input int unsigned s);
        logic [63:0] half;
        logic [63:0] mag;
        half = 64'd1 << (s - 1);
        mag  = v[63] ? 64'(-v) : 64'(v);
        mag  = (mag + half) >> s;
        rnd_shift = v[63] ? -$signed(mag) : $signed(mag);
    endfunction

endpackage

// ===== hdl/cubic_bezier_easing_animator.sv =====
// Top level: cubic-bezier easing animator with a shared multiplier and serial divider.
// Restart, ignored, first, finished and end-reaching animate items go straight from idle
//   to the output state. A running animate item runs the divider for
//   M = max(FRAC_BITS,16) divider steps, then k <= BISECT_STEPS bisection rounds
//   (check, 8 multiplier slots, compare); an early exit skips the remaining checks.
// One item at a time: s_tready returns in the same cycle that m_tvalid rises, and the
//   output state holds while the previous result still waits for m_tready.
// Reset (aresetn low, synchronous): config and control registers return to their defaults, state flags clear.
module cubic_bezier_easing_animator import cbea_pkg::*; #(
    parameter int BISECT_STEPS = 10,
    parameter int FRAC_BITS    = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] now_tick
    input  logic [1:0]  s_tuser,   // [1:0] kind
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [15:0] value, [32:16] progress, [33] done_res, rest zero
    // register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int F   = FRAC_BITS;
    localparam int TW  = F + 1;                 // t, u, basis terms up to ONE
    localparam int BW  = F + 2;                 // b1, b2 up to 3*ONE
    localparam int CW  = F + 8;                 // curve value and multiplier operands
    localparam int PW  = 2 * CW;
    localparam int M   = (F > 16) ? F : 16;     // quotient bits from the divider
    localparam int SW  = $clog2(BISECT_STEPS + 1);
    localparam logic [TW-1:0] ONE = TW'(1) << F;
    localparam logic [TW-1:0] EPS = TW'(((1 << F) + 500) / 1000);

    // configuration registers
    logic [31:0]        duration_reg, duration_next;
    logic [14:0]        x1_reg, x1_next, x2_reg, x2_next;
    logic signed [15:0] y1_reg, y1_next, y2_reg, y2_next;
    logic signed [15:0] spos_reg, spos_next, epos_reg, epos_next;

    // animation state
    logic [31:0]        start_tick_reg, start_tick_next;
    logic               started_reg, started_next;
    logic               finished_reg, finished_next;
    logic               reversed_reg, reversed_next;
    logic signed [15:0] held_value_reg, held_value_next;
    logic [16:0]        held_progress_reg, held_progress_next;

    // sequencer and datapath registers
    cbea_state_t        state_reg, state_next;
    logic [2:0]         phase_reg, phase_next;
    logic               ymode_reg, ymode_next;
    logic [SW-1:0]      step_reg, step_next;
    logic [TW-1:0]      lo_reg, lo_next, hi_reg, hi_next, t_reg, t_next;
    logic [TW-1:0]      x_reg, x_next;
    logic [TW-1:0]      uu_reg, uu_next, tt_reg, tt_next, b3_reg, b3_next;
    logic [BW-1:0]      b1_reg, b1_next, b2_reg, b2_next;
    logic signed [PW-1:0] m1_reg, m1_next;
    logic signed [CW-1:0] curve_reg, curve_next;

    // output register
    logic               m_valid_reg, m_valid_next;
    logic [33:0]        out_reg, out_next;

    // shared units
    logic signed [CW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] prod;
    logic                 div_start, div_done;
    logic [M-1:0]         quot;
    logic [31:0]          elapsed;

    // helpers
    logic [TW-1:0]        u_val;
    logic signed [15:0]   s_val, e_val;
    logic signed [16:0]   dlt;
    logic signed [CW-1:0] c1, c2, x_ext, dcur, adcur;
    logic signed [PW-1:0] trip, mid;
    logic signed [63:0]   vsum;
    logic [TW:0]          mid_sum;
    logic [TW-1:0]        lo_new, hi_new;
    logic                 accept;
    logic [1:0]           kind;

    cbea_mul #(.W(CW)) u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (prod)
    );

    cbea_div #(.QW(M)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (elapsed),
        .divisor  (duration_reg),
        .done     (div_done),
        .quot     (quot)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign kind      = s_tuser;
    assign elapsed   = s_tdata - start_tick_reg;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {6'd0, out_reg};

    always_comb begin
        // direction picks which position acts as the start
        u_val = ONE - t_reg;
        s_val = reversed_reg ? epos_reg : spos_reg;
        e_val = reversed_reg ? spos_reg : epos_reg;
        dlt   = 17'(e_val) - 17'(s_val);
        c1    = ymode_reg ? CW'(y1_reg) : CW'($signed({1'b0, x1_reg}));
        c2    = ymode_reg ? CW'(y2_reg) : CW'($signed({1'b0, x2_reg}));
        x_ext = $signed(CW'(x_reg));
        dcur  = curve_reg - x_ext;
        adcur = dcur[CW-1] ? -dcur : dcur;
        trip  = prod + (prod <<< 1);
        mid   = m1_reg + prod;
        vsum  = 64'(s_val) + rnd_shift(64'(prod), F);
        lo_new = lo_reg;
        hi_new = hi_reg;
        mid_sum = '0;

        duration_next = duration_reg;
        x1_next = x1_reg;
        y1_next = y1_reg;
        x2_next = x2_reg;
        y2_next = y2_reg;
        spos_next = spos_reg;
        epos_next = epos_reg;

        start_tick_next    = start_tick_reg;
        started_next       = started_reg;
        finished_next      = finished_reg;
        reversed_next      = reversed_reg;
        held_value_next    = held_value_reg;
        held_progress_next = held_progress_reg;

        state_next = state_reg;
        phase_next = phase_reg;
        ymode_next = ymode_reg;
        step_next  = step_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        t_next     = t_reg;
        x_next     = x_reg;
        uu_next    = uu_reg;
        tt_next    = tt_reg;
        b3_next    = b3_reg;
        b1_next    = b1_reg;
        b2_next    = b2_reg;
        m1_next    = m1_reg;
        curve_next = curve_reg;

        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_valid) begin
            case (cfg_index)
                CFG_DURATION: duration_next = cfg_data;
                CFG_X1:       x1_next   = cfg_data[14:0];
                CFG_Y1:       y1_next   = $signed(cfg_data[15:0]);
                CFG_X2:       x2_next   = cfg_data[14:0];
                CFG_Y2:       y2_next   = $signed(cfg_data[15:0]);
                CFG_START:    spos_next = $signed(cfg_data[15:0]);
                CFG_END:      epos_next = $signed(cfg_data[15:0]);
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_OUT;
                    case (kind)
                        KIND_ANIMATE: begin
                            if (!started_reg && !finished_reg) begin
                                // first step: record the start tick, answer start
                                started_next       = 1'b1;
                                start_tick_next    = s_tdata;
                                held_value_next    = s_val;
                                held_progress_next = '0;
                            end else if (finished_reg) begin
                                held_value_next    = e_val;
                                held_progress_next = PROGRESS_DONE;
                            end else if (elapsed >= duration_reg) begin
                                finished_next      = 1'b1;
                                started_next       = 1'b0;
                                start_tick_next    = '0;
                                held_value_next    = e_val;
                                held_progress_next = PROGRESS_DONE;
                            end else begin
                                div_start  = 1'b1;
                                state_next = S_DIV;
                            end
                        end
                        KIND_ONE_WAY: finished_next = 1'b0;
                        KIND_ROUND_TRIP: begin
                            if (finished_reg) begin
                                reversed_next = !reversed_reg;
                                finished_next = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_DIV: begin
                if (div_done) begin
                    x_next             = TW'(quot >> (M - F));
                    held_progress_next = 17'(quot >> (M - 16));
                    lo_next    = '0;
                    hi_next    = ONE;
                    t_next     = ONE >> 1;
                    step_next  = '0;
                    state_next = S_CHK;
                end
            end
            S_CHK: begin
                // keep bisecting while rounds remain and the bracket is wide
                ymode_next = !((step_reg < SW'(BISECT_STEPS)) && ((hi_reg - lo_reg) > EPS));
                phase_next = '0;
                state_next = S_EVAL;
            end
            S_EVAL: begin
                // issue one product per phase, capture the one issued the phase before
                case (phase_reg)
                    3'd0: begin mul_a = CW'($signed({1'b0, u_val}));
                                mul_b = CW'($signed({1'b0, u_val})); end
                    3'd1: begin mul_a = CW'($signed({1'b0, t_reg}));
                                mul_b = CW'($signed({1'b0, t_reg})); end
                    3'd2: begin mul_a = CW'($signed({1'b0, uu_reg}));
                                mul_b = CW'($signed({1'b0, t_reg})); end
                    3'd3: begin mul_a = CW'($signed({1'b0, u_val}));
                                mul_b = CW'($signed({1'b0, tt_reg})); end
                    3'd4: begin mul_a = CW'($signed({1'b0, tt_reg}));
                                mul_b = CW'($signed({1'b0, t_reg})); end
                    3'd5: begin mul_a = CW'($signed({1'b0, b1_reg})); mul_b = c1; end
                    3'd6: begin mul_a = CW'($signed({1'b0, b2_reg})); mul_b = c2; end
                    default: ;
                endcase
                case (phase_reg)
                    3'd1: uu_next = prod[F +: TW];
                    3'd2: tt_next = prod[F +: TW];
                    3'd3: b1_next = trip[F +: BW];
                    3'd4: b2_next = trip[F +: BW];
                    3'd5: b3_next = prod[F +: TW];
                    3'd6: m1_next = prod;
                    3'd7: curve_next = CW'(64'(b3_reg) + rnd_shift(64'(mid), 14));
                    default: ;
                endcase
                phase_next = phase_reg + 1'b1;
                if (phase_reg == 3'd7) begin
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                if (ymode_reg) begin
                    // scale the eased fraction by the travel distance
                    mul_a      = CW'(dlt);
                    mul_b      = curve_reg;
                    state_next = S_VAL;
                end else if (adcur < $signed(CW'(EPS))) begin
                    ymode_next = 1'b1;
                    phase_next = '0;
                    state_next = S_EVAL;
                end else begin
                    if (curve_reg < x_ext) begin
                        lo_new = t_reg;
                    end else begin
                        hi_new = t_reg;
                    end
                    mid_sum    = {1'b0, lo_new} + {1'b0, hi_new};
                    lo_next    = lo_new;
                    hi_next    = hi_new;
                    t_next     = mid_sum[TW:1];
                    step_next  = step_reg + 1'b1;
                    state_next = S_CHK;
                end
            end
            S_VAL: begin
                if (vsum > 64'sd32767) begin
                    held_value_next = 16'sh7fff;
                end else if (vsum < -64'sd32768) begin
                    held_value_next = -16'sh8000;
                end else begin
                    held_value_next = vsum[15:0];
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                // hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    out_next     = {finished_reg, held_progress_reg, held_value_reg};
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            duration_reg      <= '0;
            x1_reg            <= 15'd4096;
            y1_reg            <= 16'sd4096;
            x2_reg            <= 15'd12288;
            y2_reg            <= 16'sd12288;
            spos_reg          <= '0;
            epos_reg          <= '0;
            start_tick_reg    <= '0;
            started_reg       <= 1'b0;
            finished_reg      <= 1'b0;
            reversed_reg      <= 1'b0;
            held_value_reg    <= '0;
            held_progress_reg <= '0;
            state_reg         <= S_IDLE;
            phase_reg         <= '0;
            ymode_reg         <= 1'b0;
            step_reg          <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            duration_reg      <= duration_next;
            x1_reg            <= x1_next;
            y1_reg            <= y1_next;
            x2_reg            <= x2_next;
            y2_reg            <= y2_next;
            spos_reg          <= spos_next;
            epos_reg          <= epos_next;
            start_tick_reg    <= start_tick_next;
            started_reg       <= started_next;
            finished_reg      <= finished_next;
            reversed_reg      <= reversed_next;
            held_value_reg    <= held_value_next;
            held_progress_reg <= held_progress_next;
            state_reg         <= state_next;
            phase_reg         <= phase_next;
            ymode_reg         <= ymode_next;
            step_reg          <= step_next;
            m_valid_reg       <= m_valid_next;
        end
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        t_reg     <= t_next;
        x_reg     <= x_next;
        uu_reg    <= uu_next;
        tt_reg    <= tt_next;
        b3_reg    <= b3_next;
        b1_reg    <= b1_next;
        b2_reg    <= b2_next;
        m1_reg    <= m1_next;
        curve_reg <= curve_next;
        out_reg   <= out_next;
    end

    a_progress_range: assert property (@(posedge aclk) disable iff (!aresetn)
        held_progress_reg <= PROGRESS_DONE)
        else $error("held progress beyond done");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(started_reg && finished_reg))
        else $error("started and finished both set");

    a_bracket: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CHK) |-> (lo_reg <= t_reg) && (t_reg <= hi_reg))
        else $error("bisection point left its bracket");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg != S_IDLE))
        else $error("accepted item dropped");

endmodule

// ===== hdl/cbea_mul.sv =====
// Shared signed multiplier with a registered product.
module cbea_mul import cbea_pkg::*; #(
    parameter int W = 24
) (
    input  logic                    aclk,
    input  logic signed [W-1:0]     a,
    input  logic signed [W-1:0]     b,
    output logic signed [2*W-1:0]   p
);

    logic signed [2*W-1:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

// ===== hdl/cbea_div.sv =====
// Restoring divider, one quotient bit per cycle; dividend must be below divisor.
module cbea_div import cbea_pkg::*; #(
    parameter int QW = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [31:0]   dividend,
    input  logic [31:0]   divisor,
    output logic          done,
    output logic [QW-1:0] quot
);

    localparam int CW = $clog2(QW + 1);

    logic [31:0]   rem_reg, rem_next;
    logic [31:0]   dsr_reg, dsr_next;
    logic [QW-1:0] q_reg, q_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [32:0]   r2;
    logic          ge;

    always_comb begin
        r2        = {rem_reg, 1'b0};
        ge        = r2 >= {1'b0, dsr_reg};
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next = dividend;
            dsr_next = divisor;
            q_next   = '0;
            cnt_next = CW'(QW);
            run_next = 1'b1;
        end else if (run_reg) begin
            rem_next = ge ? 32'(r2 - {1'b0, dsr_reg}) : r2[31:0];
            q_next   = {q_reg[QW-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule
